// ----- hdl/eav_pkg.sv -----
`timescale 1ns / 1ps
package eav_pkg;

  localparam int          CHAR_W   = 8;
  localparam int          TAIL_W   = 2;
  localparam logic [TAIL_W-1:0] TAIL_MAX = 2'd3;
  localparam logic [TAIL_W-1:0] TAIL_MIN = 2'd2;

  localparam logic [CHAR_W-1:0] CH_AT     = 8'h40;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_HYPHEN = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;

  typedef struct packed {
    logic              after_separator;
    logic              local_good;
    logic              label_nonempty;
    logic              domain_good;
    logic              dot_seen;
    logic              prefix_good_at_dot;
    logic [TAIL_W-1:0] tail_letter_count;
    logic              tail_all_letters;
  } eav_flags_t;

  localparam eav_flags_t FLAGS_RESET = '{
    after_separator:    1'b0,
    local_good:         1'b1,
    label_nonempty:     1'b0,
    domain_good:        1'b1,
    dot_seen:           1'b0,
    prefix_good_at_dot: 1'b0,
    tail_letter_count:  '0,
    tail_all_letters:   1'b1
  };

  function automatic logic is_letter(input logic [CHAR_W-1:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return is_letter(c) || ((c >= 8'h30) && (c <= 8'h39));
  endfunction

endpackage

// ----- hdl/email_address_validator_core.sv -----
`timescale 1ns / 1ps
// The final byte passes the input register and then the output register on its way to out_valid.
// Throughput: one byte per cycle; an input register and an output register
// separate the channels, and only final bytes wait on a stalled output.
// Reset (rst_n low, synchronous) empties both registers and returns the
// scan flags to the start-of-string state.
module email_address_validator_core import eav_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] in_char_byte,
  input  logic              in_end_of_string,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_is_valid
);

  logic              s1_valid_r, s1_valid_nxt;
  logic [CHAR_W-1:0] s1_char_r;
  logic              s1_eos_r;
  logic              s1_adv;
  logic              out_valid_r, out_valid_nxt;
  logic              out_is_valid_r;
  logic              verdict;

  assign s1_adv   = s1_valid_r && (!s1_eos_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  eav_scan u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (s1_adv),
    .char_byte     (s1_char_r),
    .end_of_string (s1_eos_r),
    .verdict       (verdict)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) s1_valid_nxt = in_valid;
    out_valid_nxt = out_valid_r && !out_ready;
    if (s1_adv && s1_eos_r) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r <= in_char_byte;
      s1_eos_r  <= in_end_of_string;
    end
    if (s1_adv && s1_eos_r) begin
      out_is_valid_r <= verdict;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_is_valid = out_is_valid_r;

endmodule

// ----- hdl/eav_scan.sv -----
`timescale 1ns / 1ps
module eav_scan import eav_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic [CHAR_W-1:0] char_byte,
  input  logic              end_of_string,
  output logic              verdict
);

  eav_flags_t flags_r;
  eav_flags_t flags_nxt;
  eav_flags_t upd;

  always_comb begin
    upd = flags_r;
    if (!flags_r.after_separator) begin
      if (char_byte == CH_AT) begin
        if (!flags_r.label_nonempty) upd.local_good = 1'b0;
        upd.after_separator = 1'b1;
        upd.label_nonempty  = 1'b0;
      end else if (char_byte == CH_DOT) begin
        if (!flags_r.label_nonempty) upd.local_good = 1'b0;
        upd.label_nonempty = 1'b0;
      end else if (is_alnum(char_byte) || char_byte == CH_UNDER ||
                   char_byte == CH_PLUS || char_byte == CH_HYPHEN) begin
        upd.label_nonempty = 1'b1;
      end else begin
        upd.local_good = 1'b0;
      end
    end else begin
      if (char_byte == CH_DOT) begin
        upd.prefix_good_at_dot = flags_r.domain_good && flags_r.label_nonempty;
        upd.dot_seen           = 1'b1;
        upd.tail_letter_count  = '0;
        upd.tail_all_letters   = 1'b1;
      end else if (is_letter(char_byte)) begin
        if (flags_r.tail_letter_count != TAIL_MAX)
          upd.tail_letter_count = flags_r.tail_letter_count + 1'b1;
      end else begin
        upd.tail_all_letters = 1'b0;
      end

      if (char_byte == CH_DOT || char_byte == CH_HYPHEN) begin
        if (!flags_r.label_nonempty) upd.domain_good = 1'b0;
        upd.label_nonempty = 1'b0;
      end else if (is_alnum(char_byte)) begin
        upd.label_nonempty = 1'b1;
      end else begin
        upd.domain_good = 1'b0;
      end
    end
  end

  assign verdict = upd.after_separator && upd.local_good && upd.dot_seen &&
                   upd.prefix_good_at_dot && (upd.tail_letter_count >= TAIL_MIN) &&
                   upd.tail_all_letters;

  always_comb begin
    flags_nxt = flags_r;
    if (advance) flags_nxt = end_of_string ? FLAGS_RESET : upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= FLAGS_RESET;
    end else begin
      flags_r <= flags_nxt;
    end
  end

endmodule
